>>> rtl/core/bce_pkg.sv
// Shared types, constants and codes for the battery charge estimator.
`timescale 1ns / 1ps
package bce_pkg;

  localparam int ADC_W   = 10;
  localparam int LEVEL_W = 3;
  localparam int MV_W    = 14;
  localparam int PCT_W   = 7;

  localparam int WINDOW  = 10;
  localparam int WIN_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // mV = adc * 3300 / 256
  localparam int MV_NUM   = 3300;
  localparam int MV_SHIFT = 8;
  localparam int PROD_W   = ADC_W + 12;

  localparam int PCT_MAX  = 100;
  localparam int REM_W    = 21;
  localparam int KCNT_W   = $clog2(PCT_W);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = MV_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAVY_LEVEL_A  = 3'd0,
    REG_HEAVY_LEVEL_B  = 3'd1,
    REG_FULL_MV_HEAVY  = 3'd2,
    REG_EMPTY_MV_HEAVY = 3'd3,
    REG_FULL_MV_LIGHT  = 3'd4,
    REG_EMPTY_MV_LIGHT = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SETUP,
    S_DIV,
    S_WRITE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic keep_level;
    logic setup;
    logic div_step;
    logic write;
    logic scan_step;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic same_level;
    logic need_div;
    logic div_last;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/core/bce_if.sv
// Sample and result channel interfaces.
`timescale 1ns / 1ps
interface bce_sample_if;
  logic                          valid;
  logic                          ready;
  logic [bce_pkg::ADC_W-1:0]     adc_sample;
  logic [bce_pkg::LEVEL_W-1:0]   level_code;

  modport source (output valid, output adc_sample, output level_code, input ready);
  modport sink   (input valid, input adc_sample, input level_code, output ready);
endinterface

interface bce_result_if;
  logic                          valid;
  logic                          ready;
  logic [bce_pkg::MV_W-1:0]      battery_mv;
  logic [bce_pkg::PCT_W-1:0]     charge_percent;
  logic                          charge_updated;

  modport source (output valid, output battery_mv, output charge_percent,
                  output charge_updated, input ready);
  modport sink   (input valid, input battery_mv, input charge_percent,
                  input charge_updated, output ready);
endinterface

>>> rtl/core/battery_charge_estimator_core.sv
// Top level of the battery charge estimator: sequencer plus datapath.
`timescale 1ns / 1ps
// Flow: a word whose level code changed goes from the check straight to the output;
//   otherwise setup, the 7-step percent divider (skipped when setup finds a
//   clamped or zero-span percent), the window write and the max scan follow.
// One word at a time; the next word is taken the cycle after the result is
//   loaded into the output register, which waits until that register is free.
// Reset (rst, synchronous): config to defaults; window, level, held, output clear.
module battery_charge_estimator_core (
  input  logic                           clk,
  input  logic                           rst,
  bce_sample_if.sink                     sample,
  bce_result_if.source                   result,
  input  logic                           cfg_we,
  input  logic [bce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bce_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bce_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The sequencer walks check, setup, divide, window write and scan; the
  // datapath owns every data register and reports counters and compares back.
  bce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (sample.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Output register sits in the datapath, so a finished word can wait on
  // result.ready while the next sample is already accepted and processed.
  bce_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_adc    (sample.adc_sample),
    .in_level  (sample.level_code),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_mv    (result.battery_mv),
    .out_pct   (result.charge_percent),
    .out_upd   (result.charge_updated)
  );

  a_in_idle: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> !sample.ready)
    else $error("second word accepted while one is in work");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.charge_percent <= PCT_W'(PCT_MAX))
    else $error("charge percent above full scale");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid && $stable(result.battery_mv) &&
      $stable(result.charge_percent) && $stable(result.charge_updated))
    else $error("result word changed while waiting");

endmodule

>>> rtl/core/bce_ctrl.sv
// Sequencer for the charge estimator: issues datapath commands per word.
`timescale 1ns / 1ps
module bce_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  bce_pkg::sts_t  sts,
  output bce_pkg::cmd_t  cmd
);
  import bce_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.same_level) begin
          state_next = S_SETUP;
        end else begin
          cmd.keep_level = 1'b1;
          state_next     = S_DONE;
        end
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        // setup already resolved clamped and zero-span cases
        if (sts.need_div) begin
          cmd.div_step = 1'b1;
          if (sts.div_last) state_next = S_WRITE;
        end else begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.write  = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command in a cycle");

  a_check_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_CHECK)
    else $error("load not followed by level check");

  a_publish_ends: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> in_ready)
    else $error("not ready for a new word after publishing");

endmodule

>>> rtl/core/bce_datapath.sv
// Datapath: config registers, mV scaling, percent divider, window and max scan.
`timescale 1ns / 1ps
module bce_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bce_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [bce_pkg::ADC_W-1:0]     in_adc,
  input  logic [bce_pkg::LEVEL_W-1:0]   in_level,
  input  bce_pkg::cmd_t                 cmd,
  output bce_pkg::sts_t                 sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bce_pkg::MV_W-1:0]      out_mv,
  output logic [bce_pkg::PCT_W-1:0]     out_pct,
  output logic                          out_upd
);
  import bce_pkg::*;

  // configuration
  logic [LEVEL_W-1:0] heavy_a, heavy_b;
  logic [MV_W-1:0]    full_heavy, empty_heavy, full_light, empty_light;

  // state
  logic [LEVEL_W-1:0] prev_level;
  logic [PCT_W-1:0]   win [WINDOW];
  logic [WIN_W-1:0]   wpos;
  logic [PCT_W-1:0]   held;

  // working registers
  logic [LEVEL_W-1:0] level_r;
  logic [MV_W-1:0]    mv_r;
  logic [MV_W-1:0]    span_r;
  logic [REM_W-1:0]   rem;
  logic [KCNT_W-1:0]  kcnt;
  logic               need_div;
  logic [PCT_W-1:0]   pct_r;
  logic [WIN_W-1:0]   scan_idx;
  logic [PCT_W-1:0]   best;
  logic               upd_r;

  logic [PROD_W-1:0]  prod;
  logic [MV_W-1:0]    full_sel, empty_sel;
  logic [MV_W:0]      span, num;
  logic               span_pos, num_pos, num_lt;
  logic [REM_W:0]     trial;
  logic [PCT_W-1:0]   cur, max_now;

  assign prod = PROD_W'(in_adc) * PROD_W'(MV_NUM);

  always_comb begin
    if (level_r == heavy_a || level_r == heavy_b) begin
      full_sel  = full_heavy;
      empty_sel = empty_heavy;
    end else begin
      full_sel  = full_light;
      empty_sel = empty_light;
    end
  end

  // 15-bit two's complement differences; the top bit is the sign
  assign span     = {1'b0, full_sel} - {1'b0, empty_sel};
  assign num      = {1'b0, mv_r} - {1'b0, empty_sel};
  assign span_pos = !span[MV_W] && (span[MV_W-1:0] != '0);
  assign num_pos  = !num[MV_W] && (num[MV_W-1:0] != '0);
  assign num_lt   = num[MV_W-1:0] < span[MV_W-1:0];

  // one restoring quotient bit per step, MSB first
  assign trial = {1'b0, rem} - ({1'b0, REM_W'(span_r)} << kcnt);

  assign cur     = win[scan_idx];
  assign max_now = (cur > best) ? cur : best;

  assign sts.same_level = (level_r == prev_level);
  assign sts.need_div   = need_div;
  assign sts.div_last   = (kcnt == '0);
  assign sts.scan_last  = (scan_idx == WIN_W'(WINDOW - 1));
  assign sts.out_free   = !out_valid || out_ready;

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      heavy_a     <= LEVEL_W'(2);
      heavy_b     <= LEVEL_W'(3);
      full_heavy  <= MV_W'(7700);
      empty_heavy <= MV_W'(5900);
      full_light  <= MV_W'(8200);
      empty_light <= MV_W'(6000);
      prev_level  <= '0;
      wpos        <= '0;
      held        <= '0;
      out_valid   <= 1'b0;
      for (int i = 0; i < WINDOW; i++) win[i] <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_HEAVY_LEVEL_A:  heavy_a     <= cfg_data[LEVEL_W-1:0];
          REG_HEAVY_LEVEL_B:  heavy_b     <= cfg_data[LEVEL_W-1:0];
          REG_FULL_MV_HEAVY:  full_heavy  <= cfg_data;
          REG_EMPTY_MV_HEAVY: empty_heavy <= cfg_data;
          REG_FULL_MV_LIGHT:  full_light  <= cfg_data;
          REG_EMPTY_MV_LIGHT: empty_light <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.keep_level) prev_level <= level_r;
      if (cmd.write) begin
        win[wpos] <= pct_r;
        wpos      <= (wpos == WIN_W'(WINDOW - 1)) ? '0 : wpos + 1'b1;
      end
      if (cmd.scan_step && sts.scan_last) held <= max_now;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      level_r <= in_level;
      mv_r    <= prod[MV_SHIFT +: MV_W];
      upd_r   <= 1'b0;
    end
    if (cmd.setup) begin
      span_r   <= span[MV_W-1:0];
      rem      <= REM_W'(num[MV_W-1:0]) * REM_W'(PCT_MAX);
      kcnt     <= KCNT_W'(PCT_W - 1);
      need_div <= span_pos && num_pos && num_lt;
      pct_r    <= (span_pos && num_pos && !num_lt) ? PCT_W'(PCT_MAX) : '0;
    end
    if (cmd.div_step) begin
      if (!trial[REM_W]) begin
        rem         <= trial[REM_W-1:0];
        pct_r[kcnt] <= 1'b1;
      end
      kcnt <= kcnt - 1'b1;
    end
    if (cmd.write) begin
      scan_idx <= '0;
      best     <= '0;
      upd_r    <= 1'b1;
    end
    if (cmd.scan_step) begin
      best     <= max_now;
      scan_idx <= scan_idx + 1'b1;
    end
    if (cmd.publish) begin
      out_mv  <= mv_r;
      out_pct <= (cmd.scan_step && sts.scan_last) ? max_now : held;
      out_upd <= upd_r;
    end
  end

  a_held_range: assert property (@(posedge clk) disable iff (rst)
    held <= PCT_W'(PCT_MAX))
    else $error("held charge above full scale");

  a_div_range: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step && sts.div_last |=> pct_r < PCT_W'(PCT_MAX))
    else $error("divider quotient out of range");

  a_write_marks: assert property (@(posedge clk) disable iff (rst)
    cmd.write |=> upd_r && win[$past(wpos)] == $past(pct_r))
    else $error("window write lost");

endmodule

>>> tb/tb_battery_charge_estimator_core.sv
// Self-checking testbench for battery_charge_estimator_core: directed and random sample words.
`timescale 1ns / 1ps
module tb_battery_charge_estimator_core;
  import bce_pkg::*;

  // Cycles with no handshake on either channel before the run is declared hung.
  // This is many times the slowest word, its random gap and output stall included.
  localparam int IDLE_LIMIT = 1000;
  // Cycles to let pass after the last result.
  localparam int TAIL_CYCLES = WINDOW + 12;

  // Index codes past the end of the register list: writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [MV_W-1:0]  mv;
    logic [PCT_W-1:0] pct;
    logic             updated;
  } reading_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bce_sample_if smp ();
  bce_result_if res ();

  battery_charge_estimator_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (smp),
    .result    (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor copy of the configuration
  logic [LEVEL_W-1:0] m_heavy_a;
  logic [LEVEL_W-1:0] m_heavy_b;
  logic [MV_W-1:0]    m_full_h;
  logic [MV_W-1:0]    m_empty_h;
  logic [MV_W-1:0]    m_full_l;
  logic [MV_W-1:0]    m_empty_l;

  // Predictor copy of the state
  logic [LEVEL_W-1:0] m_prev_level;
  logic [PCT_W-1:0]   m_window [WINDOW];
  int                 m_pos;
  logic [PCT_W-1:0]   m_held;

  reading_t pending[$];   // readings still owed by the core, oldest first
  int       mismatches;
  int       idle_cycles;
  bit       steady;       // when set, neither side idles
  bit       smp_live;     // sample valid is currently driven high

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Expected reading for one sample word; advances the predictor state.
  function automatic reading_t estimate_charge(logic [ADC_W-1:0] adc, logic [LEVEL_W-1:0] lvl);
    reading_t r;
    int mv;
    int full;
    int empty;
    int span;
    int q;
    mv = (int'(adc) * 3300) / 256;
    r.updated = 1'b0;
    if (lvl != m_prev_level) begin
      // level change: remember it, window and held charge untouched
      m_prev_level = lvl;
    end else begin
      if (lvl == m_heavy_a || lvl == m_heavy_b) begin
        full  = int'(m_full_h);
        empty = int'(m_empty_h);
      end else begin
        full  = int'(m_full_l);
        empty = int'(m_empty_l);
      end
      span = full - empty;
      if (span <= 0) begin
        q = 0;
      end else begin
        q = ((mv - empty) * 100) / span;   // truncates toward zero
        if (q > 100) q = 100;
        if (q < 0) q = 0;
      end
      m_window[m_pos] = q[PCT_W-1:0];
      m_pos = (m_pos + 1) % WINDOW;
      m_held = '0;
      foreach (m_window[i]) begin
        if (m_window[i] > m_held) m_held = m_window[i];
      end
      r.updated = 1'b1;
    end
    r.mv  = mv[MV_W-1:0];
    r.pct = m_held;
    return r;
  endfunction

  // Drop sample valid if it is still up from the last word.
  task automatic park_sample();
    if (smp_live) begin
      smp.valid <= 1'b0;
      smp_live = 1'b0;
    end
  endtask

  // Offer one sample word after a random gap (none while steady); returns at the edge that takes it.
  task automatic send_reading(input logic [ADC_W-1:0] adc, input logic [LEVEL_W-1:0] lvl);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      park_sample();
      repeat (gap) @(posedge clk);
    end
    smp.valid      <= 1'b1;
    smp.adc_sample <= adc;
    smp.level_code <= lvl;
    smp_live = 1'b1;
    do @(posedge clk); while (!smp.ready);
    pending.push_back(estimate_charge(adc, lvl));
  endtask

  // Sender pauses until every owed reading is back, then lets the core settle.
  task automatic wait_results();
    park_sample();
    while (pending.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // One register write; leaves the write enable up for a following write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_HEAVY_LEVEL_A:  m_heavy_a = data[LEVEL_W-1:0];
      REG_HEAVY_LEVEL_B:  m_heavy_b = data[LEVEL_W-1:0];
      REG_FULL_MV_HEAVY:  m_full_h  = data;
      REG_EMPTY_MV_HEAVY: m_empty_h = data;
      REG_FULL_MV_LIGHT:  m_full_l  = data;
      REG_EMPTY_MV_LIGHT: m_empty_l = data;
      default: ;          // past the end of the list: ignored
    endcase
  endtask

  // Write all six registers plus one ignored index. Call only when the core is idle.
  task automatic apply_config(input logic [CFG_DATA_W-1:0] lvl_a, input logic [CFG_DATA_W-1:0] lvl_b,
                              input logic [CFG_DATA_W-1:0] fh, input logic [CFG_DATA_W-1:0] eh,
                              input logic [CFG_DATA_W-1:0] fl, input logic [CFG_DATA_W-1:0] el);
    write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_DATA_W'($urandom()));
    write_reg(REG_HEAVY_LEVEL_A, lvl_a);
    write_reg(REG_HEAVY_LEVEL_B, lvl_b);
    write_reg(REG_FULL_MV_HEAVY, fh);
    write_reg(REG_EMPTY_MV_HEAVY, eh);
    write_reg(REG_FULL_MV_LIGHT, fl);
    write_reg(REG_EMPTY_MV_LIGHT, el);
    cfg_we <= 1'b0;
  endtask

  // Reset defaults: zero and full scale, clamps on both sides, heavy and light pairs,
  // level changes that skip the window.
  task automatic test_defaults();
    send_reading(10'd0, 3'd0);       // same level as reset, 0 mV
    send_reading(10'd1023, 3'd0);    // full scale, clamps to 100
    send_reading(10'd465, 3'd0);     // just below light empty
    send_reading(10'd500, 3'd2);     // level change
    send_reading(10'd500, 3'd2);     // heavy pair, mid span
    send_reading(10'd597, 3'd3);     // level change
    send_reading(10'd597, 3'd3);     // heavy, just under full
    send_reading(10'd600, 3'd3);     // heavy, above full
    send_reading(10'd636, 3'd4);     // level change to a light level
    send_reading(10'd636, 3'd4);
  endtask

  // Register extremes: full range span, inverted span, zero span, span of one,
  // both heavy codes equal, level codes with the upper data bits set.
  task automatic test_config_extremes();
    wait_results();
    apply_config(14'h3FFF, 14'h3FF8, 14'd16383, 14'd0, 14'd0, 14'd16383);
    send_reading(10'd1023, 3'd7);    // level change
    send_reading(10'd1023, 3'd7);    // heavy 0..16383
    send_reading(10'd0, 3'd0);       // level change
    send_reading(10'd0, 3'd0);       // heavy via second code
    send_reading(10'd512, 3'd1);     // level change
    send_reading(10'd512, 3'd1);     // light span negative
    wait_results();
    apply_config(14'h3FFD, 14'h0005, 14'd8000, 14'd8000, 14'd1, 14'd0);
    send_reading(10'd620, 3'd5);     // level change
    send_reading(10'd620, 3'd5);     // heavy span zero
    send_reading(10'd1, 3'd6);       // level change
    send_reading(10'd1, 3'd6);       // light span of one, far above full
  endtask

  // A peak must be held for exactly WINDOW entries, then age out.
  task automatic test_window_aging();
    wait_results();
    apply_config(14'd2, 14'd3, 14'd7700, 14'd5900, 14'd8200, 14'd6000);
    send_reading(10'd1023, 3'd6);
    repeat (WINDOW) send_reading(10'd480, 3'd6);
  endtask

  task automatic draw_voltage_pair(output logic [CFG_DATA_W-1:0] full,
                                   output logic [CFG_DATA_W-1:0] empty);
    int lo;
    case ($urandom_range(0, 9))
      0: begin
        full  = 14'd16383;
        empty = 14'd0;
      end
      1: begin
        full  = CFG_DATA_W'($urandom_range(0, 16383));
        empty = full;
      end
      2: begin
        empty = CFG_DATA_W'($urandom_range(1, 16383));
        full  = CFG_DATA_W'($urandom_range(0, int'(empty) - 1));
      end
      3: begin
        full  = CFG_DATA_W'($urandom());
        empty = CFG_DATA_W'($urandom());
      end
      default: begin
        lo    = $urandom_range(0, 12000);
        empty = CFG_DATA_W'(lo);
        full  = CFG_DATA_W'(lo + $urandom_range(1, 4000));
      end
    endcase
  endtask

  // Random sessions: each one drains, draws a new configuration, then sends runs
  // of words on one level (most of them reach the window) with some noise.
  task automatic test_random_sessions(input int total);
    int sent;
    int session;
    int count;
    int run_left;
    int full;
    int empty;
    int lo_mv;
    int hi_mv;
    int adc_lo;
    int adc_hi;
    logic [LEVEL_W-1:0] run_lvl;
    logic [LEVEL_W-1:0] lvl;
    logic [ADC_W-1:0] adc;
    logic [CFG_DATA_W-1:0] fh;
    logic [CFG_DATA_W-1:0] eh;
    logic [CFG_DATA_W-1:0] fl;
    logic [CFG_DATA_W-1:0] el;
    sent = 0;
    session = 0;
    run_left = 0;
    run_lvl = '0;
    while (sent < total) begin
      wait_results();
      draw_voltage_pair(fh, eh);
      draw_voltage_pair(fl, el);
      apply_config(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()), fh, eh, fl, el);
      steady = (session % 4 == 3);
      count = $urandom_range(40, 120);
      repeat (count) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: any level, any sample
          lvl = LEVEL_W'($urandom());
          adc = ADC_W'($urandom());
        end else begin
          if (run_left == 0) begin
            run_lvl  = LEVEL_W'($urandom());
            run_left = $urandom_range(1, 24);
          end
          run_left--;
          lvl = run_lvl;
          if (lvl == m_heavy_a || lvl == m_heavy_b) begin
            full  = int'(m_full_h);
            empty = int'(m_empty_h);
          end else begin
            full  = int'(m_full_l);
            empty = int'(m_empty_l);
          end
          // half the samples land around the active span, the rest anywhere
          lo_mv  = ((full < empty) ? full : empty) - 300;
          hi_mv  = ((full < empty) ? empty : full) + 300;
          adc_lo = (lo_mv * 256) / 3300;
          adc_hi = (hi_mv * 256) / 3300 + 1;
          if (adc_lo < 0) adc_lo = 0;
          if (adc_lo > 1023) adc_lo = 1023;
          if (adc_hi > 1023) adc_hi = 1023;
          if ($urandom_range(0, 1)) adc = ADC_W'($urandom_range(0, 1023));
          else adc = ADC_W'($urandom_range(adc_lo, adc_hi));
        end
        send_reading(adc, lvl);
        sent++;
      end
      session++;
    end
    steady = 1'b0;
  endtask

  // Result side: random stall before each word (none while steady), ready held until it is taken.
  initial begin
    int stall;
    res.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (!res.valid);
    end
  end

  // Compare each accepted result word with the oldest owed reading.
  always @(posedge clk) begin
    reading_t want;
    if (!rst && res.valid && res.ready) begin
      if (pending.size() == 0) begin
        $error("result word with no reading owed: battery_mv %0d charge_percent %0d",
               res.battery_mv, res.charge_percent);
        mismatches++;
      end else begin
        want = pending.pop_front();
        if (res.battery_mv !== want.mv) begin
          $error("battery_mv: expected %0d, actual %0d", want.mv, res.battery_mv);
          mismatches++;
        end
        if (res.charge_percent !== want.pct) begin
          $error("charge_percent: expected %0d, actual %0d", want.pct, res.charge_percent);
          mismatches++;
        end
        if (res.charge_updated !== want.updated) begin
          $error("charge_updated: expected %0d, actual %0d", want.updated, res.charge_updated);
          mismatches++;
        end
      end
    end
  end

  // Hang detector: no word moving on either channel for too long.
  always @(posedge clk) begin
    if (rst || (smp.valid && smp.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    smp.valid      = 1'b0;
    smp.adc_sample = '0;
    smp.level_code = '0;
    smp_live       = 1'b0;
    steady         = 1'b0;
    mismatches     = 0;
    idle_cycles    = 0;
    // predictor starts from the reset state of the core
    m_heavy_a    = 3'd2;
    m_heavy_b    = 3'd3;
    m_full_h     = 14'd7700;
    m_empty_h    = 14'd5900;
    m_full_l     = 14'd8200;
    m_empty_l    = 14'd6000;
    m_prev_level = '0;
    m_pos        = 0;
    m_held       = '0;
    foreach (m_window[i]) m_window[i] = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_defaults();
    test_config_extremes();
    test_window_aging();
    test_random_sessions(1000);

    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/bce_pkg.sv
rtl/core/bce_if.sv
rtl/core/bce_ctrl.sv
rtl/core/bce_datapath.sv
rtl/core/battery_charge_estimator_core.sv
tb/tb_battery_charge_estimator_core.sv
